// ===== src/sha1_hash_core_assert.svh =====
// assertion macros for the sha1 core checks
`ifndef SHA1_HASH_CORE_ASSERT_SVH
`define SHA1_HASH_CORE_ASSERT_SVH

// antecedent in this cycle, consequent in the next cycle
`define SHA1_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sha1 check failed");

// antecedent and consequent in the same cycle
`define SHA1_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sha1 check failed");

`endif

// ===== src/sha1_pkg.sv =====
package sha1_pkg;

   typedef struct packed {
      logic [31:0] msg_word;
      logic [2:0]  byte_count;
      logic        end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef logic [4:0][31:0] chain_type;

   typedef struct packed {
      logic        load;
      logic        start;
      logic        run;
      logic        fold;
      logic        init;
   } engine_ctl_type;

   typedef struct packed {
      logic        last_round;
   } engine_sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMP,
      ST_FOLD,
      ST_PAD80,
      ST_PADZ,
      ST_LENHI,
      ST_LENLO,
      ST_OUT
   } back_state_type;

   localparam int IN_QUEUE_DEPTH  = 4;
   localparam int OUT_QUEUE_DEPTH = 4;

   localparam chain_type H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};

   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   localparam logic [31:0] PAD_WORD   = 32'h80000000;
   localparam logic [2:0]  MAX_BYTES  = 3'd4;
   localparam logic [3:0]  LEN_SLOT   = 4'd14;
   localparam logic [3:0]  LAST_SLOT  = 4'd15;
   localparam logic [6:0]  LAST_ROUND = 7'd79;
   localparam logic [2:0]  LAST_INDEX = 3'd4;

   function automatic logic [31:0] sha1_mask(input logic [31:0] data, input logic [2:0] cnt);
      logic [31:0] res;
      unique case (cnt)
         3'd0:    res = 32'h0;
         3'd1:    res = data & 32'hFF000000;
         3'd2:    res = data & 32'hFFFF0000;
         3'd3:    res = data & 32'hFFFFFF00;
         default: res = data;
      endcase
      return res;
   endfunction

endpackage

// ===== src/sha1_fifo.sv =====
module sha1_fifo
   import sha1_pkg::*;
#(
   parameter int DEPTH = IN_QUEUE_DEPTH,
   parameter type data_type = req_type
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  data_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output data_type rd_data,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   data_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== src/sha1_front.sv =====
module sha1_front
   import sha1_pkg::*;
#(
   parameter int DEPTH = IN_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_data,
   output logic    full,
   output req_type item,
   output logic    item_valid,
   input  logic    item_pop
);

   req_type clean;
   logic    item_empty;

   // byte counts above four saturate, unused low bytes are cleared
   always_comb begin
      clean = req_data;
      if (req_data.byte_count > MAX_BYTES) begin
         clean.byte_count = MAX_BYTES;
      end
      clean.msg_word = sha1_mask(req_data.msg_word, clean.byte_count);
   end

   sha1_fifo #(
      .DEPTH     (DEPTH),
      .data_type (req_type)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (clean),
      .full    (full),
      .rd_en   (item_pop),
      .rd_data (item),
      .empty   (item_empty)
   );

   assign item_valid = !item_empty;

endmodule

// ===== src/sha1_engine.sv =====
module sha1_engine
   import sha1_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  engine_ctl_type ctl,
   input  logic [31:0]    word_in,
   output engine_sts_type sts,
   output chain_type      chain
);

   logic [15:0][31:0] window_ff, window_in;
   logic [6:0]        round_ff, round_in;
   logic [31:0]       a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]       a_in, b_in, c_in, d_in, e_in;
   chain_type         chain_ff, chain_in;
   logic [31:0]       f_val, k_val, sched, sum, new_word;

   assign sts.last_round = (round_ff == LAST_ROUND);
   assign chain          = chain_ff;

   // message schedule, w[t+16] from the window taps
   assign sched    = window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0];
   assign new_word = ctl.load ? word_in : {sched[30:0], sched[31]};

   always_comb begin
      priority if (round_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_0;
      end else if (round_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_1;
      end else if (round_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_3;
      end
   end

   assign sum = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + window_ff[0];

   always_comb begin
      window_in = window_ff;
      round_in  = round_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      e_in      = e_ff;
      chain_in  = chain_ff;
      if (ctl.load || ctl.run) begin
         window_in = {new_word, window_ff[15:1]};
      end
      if (ctl.start) begin
         round_in = '0;
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         e_in     = chain_ff[4];
      end else if (ctl.run) begin
         round_in = round_ff + 1'b1;
         a_in     = sum;
         b_in     = a_ff;
         c_in     = {b_ff[1:0], b_ff[31:2]};
         d_in     = c_ff;
         e_in     = d_ff;
      end
      if (ctl.init) begin
         chain_in = H_INIT;
      end else if (ctl.fold) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= H_INIT;
         round_ff <= '0;
      end else begin
         chain_ff <= chain_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      d_ff      <= d_in;
      e_ff      <= e_in;
   end

endmodule

// ===== src/sha1_back.sv =====
module sha1_back
   import sha1_pkg::*;
#(
   parameter int DEPTH = OUT_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type item,
   input  logic    item_valid,
   output logic    item_pop,
   output rsp_type rsp_data,
   output logic    empty,
   input  logic    pop
);

   back_state_type state_ff, state_in;
   back_state_type ret_ff, ret_in;
   logic [31:0]    acc_ff, acc_in;
   logic [1:0]     acc_cnt_ff, acc_cnt_in;
   logic [3:0]     nwords_ff, nwords_in;
   logic [63:0]    bit_len_ff, bit_len_in;
   logic [2:0]     out_idx_ff, out_idx_in;

   logic           pk_en;
   logic [31:0]    pk_data;
   logic [2:0]     pk_cnt;
   logic [63:0]    merged;
   logic [2:0]     total;
   logic           word_done;
   logic           block_full;

   engine_ctl_type ctl;
   engine_sts_type sts;
   chain_type      chain;

   logic           out_wr;
   logic           out_full;
   rsp_type        out_data;
   logic           finish;

   // byte packer: append pk_cnt bytes behind the partial word
   assign merged     = {acc_ff, 32'h0} | ({pk_data, 32'h0} >> {acc_cnt_ff, 3'b000});
   assign total      = {1'b0, acc_cnt_ff} + pk_cnt;
   assign word_done  = pk_en && total[2];
   assign block_full = word_done && (nwords_ff == LAST_SLOT);

   // outputs of the sequencer
   always_comb begin
      item_pop  = 1'b0;
      pk_en     = 1'b0;
      pk_data   = 32'h0;
      pk_cnt    = 3'd0;
      ctl       = '0;
      out_wr    = 1'b0;
      finish    = 1'b0;
      out_data  = '{digest_word: chain[out_idx_ff], word_index: out_idx_ff,
                    last_word: (out_idx_ff == LAST_INDEX)};
      unique case (state_ff)
         ST_IDLE: begin
            item_pop = item_valid;
            pk_en    = item_valid;
            pk_data  = item.msg_word;
            pk_cnt   = item.byte_count;
         end
         ST_PAD80: begin
            pk_en   = 1'b1;
            pk_data = PAD_WORD;
            pk_cnt  = MAX_BYTES - {1'b0, acc_cnt_ff};
         end
         ST_PADZ: begin
            pk_en  = (nwords_ff != LEN_SLOT);
            pk_cnt = MAX_BYTES;
         end
         ST_LENHI: begin
            pk_en   = 1'b1;
            pk_data = bit_len_ff[63:32];
            pk_cnt  = MAX_BYTES;
         end
         ST_LENLO: begin
            pk_en   = 1'b1;
            pk_data = bit_len_ff[31:0];
            pk_cnt  = MAX_BYTES;
         end
         ST_COMP: begin
            ctl.run = 1'b1;
         end
         ST_FOLD: begin
            ctl.fold = 1'b1;
         end
         ST_OUT: begin
            out_wr   = !out_full;
            finish   = !out_full && (out_idx_ff == LAST_INDEX);
            ctl.init = finish;
         end
         default: begin
         end
      endcase
      ctl.load  = word_done;
      ctl.start = block_full;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (block_full) begin
                  state_in = ST_COMP;
                  ret_in   = item.end_of_message ? ST_PAD80 : ST_IDLE;
               end else if (item.end_of_message) begin
                  state_in = ST_PAD80;
               end
            end
         end
         ST_PAD80: begin
            state_in = ST_PADZ;
            if (block_full) begin
               state_in = ST_COMP;
               ret_in   = ST_PADZ;
            end
         end
         ST_PADZ: begin
            if (nwords_ff == LEN_SLOT) begin
               state_in = ST_LENHI;
            end else if (block_full) begin
               state_in = ST_COMP;
               ret_in   = ST_PADZ;
            end
         end
         ST_LENHI: begin
            state_in = ST_LENLO;
         end
         ST_LENLO: begin
            state_in = ST_COMP;
            ret_in   = ST_OUT;
         end
         ST_COMP: begin
            if (sts.last_round) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            state_in = ret_ff;
         end
         ST_OUT: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      acc_in     = acc_ff;
      acc_cnt_in = acc_cnt_ff;
      nwords_in  = nwords_ff;
      bit_len_in = bit_len_ff;
      out_idx_in = out_idx_ff;
      if (pk_en) begin
         acc_in     = total[2] ? merged[31:0] : merged[63:32];
         acc_cnt_in = total[1:0];
      end
      if (word_done) begin
         nwords_in = nwords_ff + 1'b1;
      end
      if (item_pop) begin
         bit_len_in = bit_len_ff + {58'h0, item.byte_count, 3'b000};
      end
      if (out_wr) begin
         out_idx_in = out_idx_ff + 1'b1;
      end
      if (finish) begin
         bit_len_in = '0;
         out_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ret_ff     <= ST_IDLE;
         acc_ff     <= '0;
         acc_cnt_ff <= '0;
         nwords_ff  <= '0;
         bit_len_ff <= '0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         acc_ff     <= acc_in;
         acc_cnt_ff <= acc_cnt_in;
         nwords_ff  <= nwords_in;
         bit_len_ff <= bit_len_in;
         out_idx_ff <= out_idx_in;
      end
   end

   sha1_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .word_in (merged[63:32]),
      .sts     (sts),
      .chain   (chain)
   );

   sha1_fifo #(
      .DEPTH     (DEPTH),
      .data_type (rsp_type)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_wr),
      .wr_data (out_data),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

endmodule

// ===== src/sha1_hash_core.sv =====
// the packer takes items only in its idle state; each full 64-byte block then runs
// 80 rounds and a fold step on the single round unit, and no further item is
// taken from the input queue until that block has been folded
// end of message: padding words, one or two compressions, then
// 5 digest transfers; synchronous reset empties both queues and restores h0..h4
module sha1_hash_core
   import sha1_pkg::*;
#(
   parameter int IN_DEPTH  = IN_QUEUE_DEPTH,
   parameter int OUT_DEPTH = OUT_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   req_type item;
   logic    item_valid;
   logic    item_pop;

   sha1_front #(
      .DEPTH (IN_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_data   (req_data),
      .full       (full),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   sha1_back #(
      .DEPTH (OUT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .rsp_data   (rsp_data),
      .empty      (empty),
      .pop        (pop)
   );

endmodule

// ===== src/sha1_hash_core_checker.sv =====
`include "sha1_hash_core_assert.svh"

module sha1_hash_core_checker
   import sha1_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   `SHA1_ASSERT_SAME(a_empty_after_reset, $past(reset), empty)
   `SHA1_ASSERT_SAME(a_last_is_h4, !empty && rsp_data.last_word, rsp_data.word_index == LAST_INDEX)
   `SHA1_ASSERT_NEXT(a_index_steps, pop && !empty && !rsp_data.last_word, empty || (rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
   `SHA1_ASSERT_NEXT(a_rsp_holds, !empty && !pop, !empty && $stable(rsp_data))

endmodule

bind sha1_hash_core sha1_hash_core_checker u_checker (.*);

// ===== test/sha1_hash_core_tb.sv =====
module sha1_hash_core_tb;
   import sha1_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ITEM_TARGET = 270;
   localparam int unsigned IDLE_LIMIT  = 4000;
   localparam int unsigned LONG_HOLD   = 800;
   localparam int unsigned SETTLE      = 300;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned MAX_COUNT   = 4;
   localparam int unsigned DIGEST_LEN  = 5;
   localparam int unsigned PAD_FILL    = 56;

   localparam logic [0:4][31:0] INIT_CHAIN = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                              32'h10325476, 32'hC3D2E1F0};
   localparam logic [0:4][31:0] EMPTY_DIGEST = {32'hDA39A3EE, 32'h5E6B4B0D, 32'h3255BFEF,
                                                32'h95601890, 32'hAFD80709};
   localparam logic [0:4][31:0] ABC_DIGEST = {32'hA9993E36, 32'h4706816A, 32'hBA3E2571,
                                              32'h7850C26C, 32'h9CD0D89D};
   localparam logic [0:4][31:0] NO_DIGEST = '0;

   localparam logic [31:0] ROUND_K0 = 32'h5A827999;
   localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
   localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
   localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   localparam int unsigned BOUNDARY_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 121, 128};

   typedef enum logic [1:0] {
      POP_ALWAYS,
      POP_MOSTLY,
      POP_RARELY,
      POP_TOGGLE
   } pop_mode_type;

   typedef struct packed {
      req_type          item;
      logic             known;
      logic [0:4][31:0] digest;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   directed_row_type directed_rows [$];
   rsp_type          digest_q [$];
   int unsigned      pending_words = 0;
   int unsigned      error_count = 0;
   int unsigned      idle_cycles = 0;
   int unsigned      item_seq = 0;
   int unsigned      items_sent = 0;
   int unsigned      burst_left = 0;
   logic             hold_request = 1'b0;

   // running hash state
   logic [0:4][31:0] chain;
   logic [7:0]       blk [64];
   int unsigned      fill;
   logic [63:0]      msg_bits;

   sha1_hash_core dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void restart_hash();
      chain = INIT_CHAIN;
      fill = 0;
      msg_bits = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) begin
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      end
      for (int i = 16; i < 80; i++) begin
         t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
         w[i] = {t[30:0], t[31]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = ROUND_K0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = ROUND_K1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = ROUND_K2;
         end else begin
            f = b ^ c ^ d;
            k = ROUND_K3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[i];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
      chain[4] = chain[4] + e;
   endfunction

   function automatic void add_byte(input logic [7:0] v);
      blk[fill] = v;
      fill++;
      if (fill == 64) begin
         compress_block();
         fill = 0;
      end
   endfunction

   // absorbs one item; returns 1 with the digest when the message ends
   function automatic logic hash_item(input req_type it, output logic [0:4][31:0] digest);
      int unsigned n;
      logic [63:0] len;
      digest = '0;
      n = (it.byte_count > MAX_COUNT) ? MAX_COUNT : it.byte_count;
      for (int i = 0; i < n; i++) begin
         add_byte(it.msg_word[31-8*i -: 8]);
         msg_bits += 64'd8;
      end
      if (!it.end_of_message) return 1'b0;
      len = msg_bits;
      add_byte(PAD_BYTE);
      while (fill != PAD_FILL) add_byte(8'h00);
      for (int i = 0; i < 8; i++) add_byte(len[63-8*i -: 8]);
      digest = chain;
      restart_hash();
      return 1'b1;
   endfunction

   function automatic void add_row(input logic [31:0] w, input logic [2:0] c, input logic e,
                                   input logic k, input logic [0:4][31:0] d);
      directed_row_type row;
      row.item.msg_word = w;
      row.item.byte_count = c;
      row.item.end_of_message = e;
      row.known = k;
      row.digest = d;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin : monitor
      logic [0:4][31:0] words;
      rsp_type exp;
      logic moved;
      if (reset) begin
         restart_hash();
         digest_q.delete();
         idle_cycles = 0;
      end else begin
         moved = 1'b0;
         if (push && !full) begin
            moved = 1'b1;
            if (hash_item(req_data, words)) begin
               if (item_seq < directed_rows.size() && directed_rows[item_seq].known)
                  words = directed_rows[item_seq].digest;
               for (int i = 0; i < DIGEST_LEN; i++) begin
                  exp.digest_word = words[i];
                  exp.word_index = 3'(i);
                  exp.last_word = (i == DIGEST_LEN - 1);
                  digest_q = {digest_q, exp};
               end
            end
            item_seq++;
         end
         if (pop && !empty) begin
            moved = 1'b1;
            if (digest_q.size() == 0) begin
               note_error($sformatf("unexpected result %h/%0d/%0b", rsp_data.digest_word,
                                    rsp_data.word_index, rsp_data.last_word));
            end else begin
               exp = digest_q.pop_front();
               if (rsp_data.digest_word !== exp.digest_word ||
                   rsp_data.word_index !== exp.word_index ||
                   rsp_data.last_word !== exp.last_word)
                  note_error($sformatf("mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                                       exp.digest_word, exp.word_index, exp.last_word,
                                       rsp_data.digest_word, rsp_data.word_index,
                                       rsp_data.last_word));
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
      pending_words = digest_q.size();
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("sha1_hash_core_tb: FAIL");
      $finish;
   end

   // result side: random stall modes, plus one long hold on request
   initial begin : receiver
      pop_mode_type mode;
      int unsigned left;
      mode = POP_ALWAYS;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if (left == 0) begin
               mode = pop_mode_type'($urandom_range(0, 3));
               left = $urandom_range(8, 80);
            end
            left--;
            case (mode)
               POP_ALWAYS: pop <= 1'b1;
               POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
               POP_RARELY: pop <= ($urandom_range(0, 3) == 0);
               default:    pop <= ~pop;
            endcase
         end
      end
   end

   task automatic send_item(input req_type it);
      if (burst_left == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                   : $urandom_range(1, 20);
      end
      req_data <= it;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      burst_left--;
      if (it.byte_count != 0 || it.end_of_message) items_sent++;
   endtask

   task automatic send_message(input int unsigned nbytes);
      int unsigned rem;
      int unsigned cnt;
      req_type it;
      rem = nbytes;
      do begin
         it.msg_word = $urandom();
         cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : MAX_COUNT;
         if (cnt > rem) cnt = rem;
         it.end_of_message = (cnt == rem) && (cnt == 0 || $urandom_range(0, 2) != 0);
         it.byte_count = 3'(cnt);
         if (cnt == MAX_COUNT && $urandom_range(0, 4) == 0)
            it.byte_count = 3'($urandom_range(5, 7));
         send_item(it);
         rem -= cnt;
      end while (!it.end_of_message);
   endtask

   task automatic wait_for_digests();
      push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      wait (pending_words == 0);
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic drained;
      drained = 1'b0;
      add_row(32'h00000000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST);
      add_row(32'h616263A5, 3'd3, 1'b1, 1'b1, ABC_DIGEST);
      add_row(32'h61FFFFFF, 3'd1, 1'b0, 1'b0, NO_DIGEST);
      add_row(32'h6263DEAD, 3'd2, 1'b0, 1'b0, NO_DIGEST);
      add_row(32'h12345678, 3'd0, 1'b0, 1'b0, NO_DIGEST);
      add_row(32'hFFFFFFFF, 3'd0, 1'b1, 1'b1, ABC_DIGEST);
      add_row(32'hFFFFFFFF, 3'd7, 1'b0, 1'b0, NO_DIGEST);
      add_row(32'h00000000, 3'd5, 1'b0, 1'b0, NO_DIGEST);
      add_row(32'hA5A5A5A5, 3'd6, 1'b1, 1'b0, NO_DIGEST);
      add_row(32'h80000000, 3'd4, 1'b1, 1'b0, NO_DIGEST);
      add_row(32'h00000000, 3'd4, 1'b1, 1'b0, NO_DIGEST);
      add_row(32'hFFFFFFFF, 3'd4, 1'b1, 1'b0, NO_DIGEST);
      add_row(32'h01234567, 3'd1, 1'b1, 1'b0, NO_DIGEST);
      add_row(32'hFEDCBA98, 3'd2, 1'b1, 1'b0, NO_DIGEST);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) send_item(directed_rows[r].item);
      wait_for_digests();

      // padding boundaries: one or two final blocks
      foreach (BOUNDARY_LEN[i]) send_message(BOUNDARY_LEN[i]);

      // results back up while short messages keep coming
      hold_request = 1'b1;
      repeat (12) send_message($urandom_range(0, 8));

      while (items_sent < ITEM_TARGET) begin
         if (!drained && items_sent > ITEM_TARGET / 2) begin
            wait_for_digests();
            drained = 1'b1;
         end
         send_message(($urandom_range(0, 7) == 0) ? $urandom_range(41, 130)
                                                  : $urandom_range(0, 40));
      end
      push <= 1'b0;
      @(posedge clock);

      wait (pending_words == 0);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && digest_q.size() == 0) begin
         $display("sha1_hash_core_tb: PASS");
      end else begin
         $display("sha1_hash_core_tb: FAIL");
      end
      $finish;
   end

endmodule
